// ===== design/calendar_date_adder_macros.svh =====
// Assertion macros shared by the calendar date adder checker.
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("calendar_date_adder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("calendar_date_adder: next-cycle check failed");

`endif

// ===== design/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Codes, constants and calendar helpers for the calendar date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    // Command codes
    localparam logic [2:0] CMD_DAYS    = 3'd0;
    localparam logic [2:0] CMD_WEEKS   = 3'd1;
    localparam logic [2:0] CMD_MONTHS  = 3'd2;
    localparam logic [2:0] CMD_YEARS   = 3'd3;
    localparam logic [2:0] CMD_DECADES = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [3:0]  DECEMBER = 4'd12;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for all 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Leap year from year-in-century and century (4/100/400 rule)
    function automatic logic is_leap(input logic [6:0] yc, input logic [7:0] cen);
        return (yc[1:0] == 2'd0) && ((yc != 7'd0) || (cen[1:0] == 2'd0));
    endfunction

    // Month length; zero for a month code outside 1..12
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/calendar_date_adder.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder
// Gregorian date adder: adds days, weeks, months, years or decades to a date.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_ready is high only while the sequencer is
// idle. The year is first split into century and year-in-century and the
// date is checked; invalid dates and unknown commands then go to finish.
// Day/week requests step over the day count (amount, or 7 * amount for weeks)
// and month requests over the month count, one unit per cycle in one shared
// stepping unit; year and decade requests add once and re-split the year.
// A finished result sits in an output register, so the next request can be
// accepted while the previous result waits for m_ready.
`default_nettype none

module calendar_date_adder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [14:0] s_amount,
    input  wire logic [4:0]  s_start_day,
    input  wire logic [3:0]  s_start_month,
    input  wire logic [13:0] s_start_year,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_new_day,
    output logic [3:0]       m_new_month,
    output logic [13:0]      m_new_year,
    output logic [1:0]       m_status
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SPLIT_MUL = 8'b0000_0010,
        S_SPLIT_SUB = 8'b0000_0100,
        S_CHECK     = 8'b0000_1000,
        S_DAYS      = 8'b0001_0000,
        S_MONTHS    = 8'b0010_0000,
        S_CLAMP     = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [14:0] amount_reg, amount_next;
    logic [17:0] cnt_reg, cnt_next;
    logic [4:0]  d_reg, d_next;
    logic [3:0]  m_reg, m_next;
    logic [13:0] y_reg, y_next;
    logic [6:0]  yc_reg, yc_next;
    logic [7:0]  cen_reg, cen_next;
    logic [7:0]  q_reg, q_next;
    logic [1:0]  status_reg, status_next;
    logic        added_reg, added_next;

    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [13:0] out_year_reg, out_year_next;
    logic [1:0]  out_status_reg, out_status_next;

    // Shared stepping unit signals
    logic [4:0]  dim_cur;
    logic [13:0] y_inc;
    logic [6:0]  yc_inc;
    logic [7:0]  cen_inc;
    logic [3:0]  m_step;
    logic [13:0] y_step;
    logic [6:0]  yc_step;
    logic [7:0]  cen_step;
    logic [4:0]  dim_step;
    logic [26:0] prod_div;
    logic [14:0] prod_cen;
    logic [14:0] yc_diff;
    logic [17:0] n_days;
    logic [18:0] n_years;
    logic [18:0] year_room;
    logic [18:0] year_sum;
    logic        date_bad;

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_new_day   = out_day_reg;
    assign m_new_month = out_month_reg;
    assign m_new_year  = out_year_reg;
    assign m_status    = out_status_reg;

    // Month length, year increment and the next-month step
    always_comb begin
        dim_cur = cda_pkg::days_in(m_reg, cda_pkg::is_leap(yc_reg, cen_reg));
        y_inc   = y_reg + 14'd1;
        if (yc_reg == 7'd99) begin
            yc_inc  = 7'd0;
            cen_inc = cen_reg + 8'd1;
        end else begin
            yc_inc  = yc_reg + 7'd1;
            cen_inc = cen_reg;
        end
        if (m_reg < cda_pkg::DECEMBER) begin
            m_step   = m_reg + 4'd1;
            y_step   = y_reg;
            yc_step  = yc_reg;
            cen_step = cen_reg;
        end else begin
            m_step   = 4'd1;
            y_step   = y_inc;
            yc_step  = yc_inc;
            cen_step = cen_inc;
        end
        dim_step = cda_pkg::days_in(m_step, cda_pkg::is_leap(yc_step, cen_step));
    end

    // Year split, validity and year addition arithmetic
    always_comb begin
        prod_div  = 27'(y_reg) * 27'(cda_pkg::DIV100_MUL);
        prod_cen  = 15'(q_reg) * 15'd100;
        yc_diff   = 15'(y_reg) - prod_cen;
        n_days    = (cmd_reg == cda_pkg::CMD_WEEKS) ? 18'(amount_reg) * 18'd7
                                                    : 18'(amount_reg);
        n_years   = (cmd_reg == cda_pkg::CMD_DECADES) ? 19'(amount_reg) * 19'd10
                                                      : 19'(amount_reg);
        year_room = 19'(cda_pkg::YEAR_MAX) - 19'(y_reg);
        year_sum  = 19'(y_reg) + n_years;
        date_bad  = (m_reg < 4'd1) || (m_reg > cda_pkg::DECEMBER) ||
                    (y_reg > cda_pkg::YEAR_MAX) || (d_reg == 5'd0) || (d_reg > dim_cur);
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        amount_next     = amount_reg;
        cnt_next        = cnt_reg;
        d_next          = d_reg;
        m_next          = m_reg;
        y_next          = y_reg;
        yc_next         = yc_reg;
        cen_next        = cen_reg;
        q_next          = q_reg;
        status_next     = status_reg;
        added_next      = added_reg;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_status_next = out_status_reg;

        // Drop the result once the transaction completes
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_cmd;
                    amount_next = s_amount;
                    d_next      = s_start_day;
                    m_next      = s_start_month;
                    y_next      = s_start_year;
                    status_next = cda_pkg::STATUS_OK;
                    added_next  = 1'b0;
                    state_next  = S_SPLIT_MUL;
                end
            end
            S_SPLIT_MUL: begin
                q_next     = prod_div[cda_pkg::DIV100_SHIFT +: 8];
                state_next = S_SPLIT_SUB;
            end
            S_SPLIT_SUB: begin
                cen_next   = q_reg;
                yc_next    = yc_diff[6:0];
                state_next = added_reg ? S_CLAMP : S_CHECK;
            end
            S_CHECK: begin
                if (date_bad) begin
                    status_next = cda_pkg::STATUS_INVALID;
                    state_next  = S_FINISH;
                end else begin
                    case (cmd_reg)
                        cda_pkg::CMD_DAYS, cda_pkg::CMD_WEEKS: begin
                            cnt_next   = n_days;
                            state_next = S_DAYS;
                        end
                        cda_pkg::CMD_MONTHS: begin
                            cnt_next   = 18'(amount_reg);
                            state_next = S_MONTHS;
                        end
                        cda_pkg::CMD_YEARS, cda_pkg::CMD_DECADES: begin
                            if (n_years > year_room) begin
                                y_next      = cda_pkg::YEAR_MAX;
                                status_next = cda_pkg::STATUS_SAT;
                            end else begin
                                y_next = year_sum[13:0];
                            end
                            added_next = 1'b1;
                            state_next = S_SPLIT_MUL;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DAYS: begin
                if (cnt_reg == 18'd0) begin
                    state_next = S_FINISH;
                end else if (d_reg < dim_cur) begin
                    d_next   = d_reg + 5'd1;
                    cnt_next = cnt_reg - 18'd1;
                end else if ((m_reg < cda_pkg::DECEMBER) || (y_reg < cda_pkg::YEAR_MAX)) begin
                    d_next   = 5'd1;
                    m_next   = m_step;
                    y_next   = y_step;
                    yc_next  = yc_step;
                    cen_next = cen_step;
                    cnt_next = cnt_reg - 18'd1;
                end else begin
                    status_next = cda_pkg::STATUS_SAT;
                    state_next  = S_FINISH;
                end
            end
            S_MONTHS: begin
                if (cnt_reg == 18'd0) begin
                    state_next = S_FINISH;
                end else if ((m_reg < cda_pkg::DECEMBER) || (y_reg < cda_pkg::YEAR_MAX)) begin
                    m_next   = m_step;
                    y_next   = y_step;
                    yc_next  = yc_step;
                    cen_next = cen_step;
                    d_next   = (d_reg > dim_step) ? dim_step : d_reg;
                    cnt_next = cnt_reg - 18'd1;
                end else begin
                    status_next = cda_pkg::STATUS_SAT;
                    state_next  = S_FINISH;
                end
            end
            S_CLAMP: begin
                // Clamp the day to the target month, e.g. a leap day in a common year
                if (d_reg > dim_cur) begin
                    d_next = dim_cur;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_day_next    = d_reg;
                    out_month_next  = m_reg;
                    out_year_next   = y_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        amount_reg     <= amount_next;
        cnt_reg        <= cnt_next;
        d_reg          <= d_next;
        m_reg          <= m_next;
        y_reg          <= y_next;
        yc_reg         <= yc_next;
        cen_reg        <= cen_next;
        q_reg          <= q_next;
        status_reg     <= status_next;
        added_reg      <= added_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ===== design/cda_checker.sv =====
// ----------------------------------------------------------------------------
// cda_checker
// Port-level assertions for the calendar date adder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_adder_macros.svh"

module cda_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [4:0]  m_new_day,
    input wire logic [3:0]  m_new_month,
    input wire logic [13:0] m_new_year,
    input wire logic [1:0]  m_status
);

    // Hold the result until its transaction completes
    `CDA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_new_day) && $stable(m_new_month) && $stable(m_new_year) && $stable(m_status))

    // One request at a time: ready drops after an accepted transaction
    `CDA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Status is one of the three defined codes
    `CDA_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_status != 2'd3)

    // A non-invalid result is a date within the calendar range
    `CDA_ASSERT_NOW(a_result_range, aclk, aresetn, m_valid && (m_status != cda_pkg::STATUS_INVALID), (m_new_day != 5'd0) && (m_new_month != 4'd0) && (m_new_month <= cda_pkg::DECEMBER) && (m_new_year <= cda_pkg::YEAR_MAX))

endmodule

bind calendar_date_adder cda_checker u_cda_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_new_day   (m_new_day),
    .m_new_month (m_new_month),
    .m_new_year  (m_new_year),
    .m_status    (m_status)
);

`default_nettype wire
